FILE: src/ecbt_pkg.sv
// ============================================================================
// ecbt_pkg
// Shared types, constants and codes for the endpoint circuit breaker table.
// ============================================================================
package ecbt_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Field widths.
    localparam int KEY_W   = 48;
    localparam int FAIL_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_BURST_WINDOW    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_EVICT_THRESHOLD = 2'd1;
    localparam logic [CIDX_W-1:0] REG_TRIP_HOLD       = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] RST_BURST_WINDOW    = 16'd100;
    localparam logic [7:0]  RST_EVICT_THRESHOLD = 8'd3;
    localparam logic [15:0] RST_TRIP_HOLD       = 16'd1000;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_REPORT = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Result codes.
    typedef enum logic [1:0] {
        CODE_DONE    = 2'd0,
        CODE_IGNORED = 2'd1,
        CODE_BROKEN  = 2'd2,
        CODE_FULL    = 2'd3
    } t_code;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [FAIL_W-1:0] failures;
        logic [TIME_W-1:0] window_start;
        logic [TIME_W-1:0] broken_until;
    } t_entry;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] burst_window;
        logic [7:0]  evict_threshold;
        logic [15:0] trip_hold;
    } t_cfg;

    // Request from the controller to the entry memory.
    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_ram_req;

endpackage

FILE: src/ecbt_in_if.sv
// ============================================================================
// ecbt_in_if
// Input item channel: valid/ready handshake with the request payload.
// ============================================================================
interface ecbt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [47:0] host_key;
    logic        is_disconnect;

    modport source (output valid, output operation, output host_key,
                    output is_disconnect, input ready);
    modport sink   (input valid, input operation, input host_key,
                    input is_disconnect, output ready);
endinterface

FILE: src/ecbt_out_if.sv
// ============================================================================
// ecbt_out_if
// Result item channel: valid/ready handshake with the result payload.
// ============================================================================
interface ecbt_out_if;
    logic       valid;
    logic       ready;
    logic       available;
    logic [1:0] result_code;
    logic       became_broken;

    modport source (output valid, output available, output result_code,
                    output became_broken, input ready);
    modport sink   (input valid, input available, input result_code,
                    input became_broken, output ready);
endinterface

FILE: src/ecbt_cfg_regs.sv
// ============================================================================
// ecbt_cfg_regs
// Configuration registers: burst window, eviction threshold and broken TTL.
// ============================================================================
module ecbt_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ecbt_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [ecbt_pkg::CFG_W-1:0]     i_cfg_data,
    output ecbt_pkg::t_cfg                 o_cfg
);

    ecbt_pkg::t_cfg r_cfg;

    // Decode the register index; writes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.burst_window    <= ecbt_pkg::RST_BURST_WINDOW;
            r_cfg.evict_threshold <= ecbt_pkg::RST_EVICT_THRESHOLD;
            r_cfg.trip_hold       <= ecbt_pkg::RST_TRIP_HOLD;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ecbt_pkg::REG_BURST_WINDOW) begin
                r_cfg.burst_window <= i_cfg_data;
            end else if (i_cfg_idx == ecbt_pkg::REG_EVICT_THRESHOLD) begin
                r_cfg.evict_threshold <= i_cfg_data[7:0];
            end else if (i_cfg_idx == ecbt_pkg::REG_TRIP_HOLD) begin
                r_cfg.trip_hold <= i_cfg_data;
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/ecbt_entry_ram.sv
// ============================================================================
// ecbt_entry_ram
// Entry memory: one write port and one read port with registered read data.
// ============================================================================
module ecbt_entry_ram (
    input  logic               i_clk,
    input  ecbt_pkg::t_ram_req i_req,
    output ecbt_pkg::t_entry   o_rdata
);

    ecbt_pkg::t_entry mem [ecbt_pkg::TABLE_ENTRIES];
    ecbt_pkg::t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ecbt_ctrl.sv
// ============================================================================
// ecbt_ctrl
// Sequencer: sweeps the entry memory for queries, disconnect reports and ticks,
// keeps valid/broken flags and tick clock, applies the report update, holds the result.
// ============================================================================
module ecbt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ecbt_pkg::t_cfg      i_cfg,
    ecbt_in_if.sink             i_item,
    ecbt_out_if.source          o_result,
    output ecbt_pkg::t_ram_req  o_ram_req,
    input  ecbt_pkg::t_entry    i_ram_rdata
);

    localparam int N     = ecbt_pkg::TABLE_ENTRIES;
    localparam int IDX_W = ecbt_pkg::IDX_W;
    localparam int CNT_W = ecbt_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWEEP  = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state                          r_state;
    ecbt_pkg::t_op                   r_op;
    logic [ecbt_pkg::KEY_W-1:0]      r_key;
    logic [ecbt_pkg::TIME_W-1:0]     r_clock_now;
    logic [N-1:0]                    r_valid;
    logic [N-1:0]                    r_broken;

    // Sweep pointers: read issue count and index of the returning data.
    logic [CNT_W-1:0]                r_rd_cnt;
    logic                            r_dv;
    logic [IDX_W-1:0]                r_didx;

    // What the sweep found.
    logic                            r_hit;
    logic                            r_hit_brk;
    logic                            r_hit_free;
    logic [IDX_W-1:0]                r_hit_slot;
    ecbt_pkg::t_entry                r_hit_word;
    logic                            r_free_found;
    logic [IDX_W-1:0]                r_free_slot;
    logic [N-1:0]                    r_free_vec;

    // Result under construction and output register.
    logic                            r_avail;
    ecbt_pkg::t_code                 r_code;
    logic                            r_became;
    logic                            r_out_valid;
    logic                            r_out_avail;
    ecbt_pkg::t_code                 r_out_code;
    logic                            r_out_became;

    // Per-entry sweep terms.
    logic                            c_issue;
    logic                            c_match;
    logic                            c_expired;
    logic                            c_free;
    logic                            c_last;
    logic [ecbt_pkg::TIME_W-1:0]     c_age;

    // Report update terms.
    logic                            n_keep;
    logic                            n_write;
    logic [IDX_W-1:0]                n_slot;
    logic [ecbt_pkg::FAIL_W-1:0]     n_fail;
    logic [ecbt_pkg::TIME_W-1:0]     n_ws;
    logic                            n_trip;
    logic [ecbt_pkg::TIME_W-1:0]     n_bu;
    logic                            n_load;
    logic [N-1:0]                    n_valid;

    // Read issue during the sweep, one entry per cycle.
    assign c_issue = (r_state == ST_SWEEP) && (r_rd_cnt != CNT_W'(N));

    // Classify the entry whose data returns this cycle.
    always_comb begin
        c_age     = r_clock_now - i_ram_rdata.window_start;
        c_match   = r_valid[r_didx] && (i_ram_rdata.key == r_key);
        c_expired = (i_ram_rdata.failures == '0)
                    || (c_age > {16'd0, i_cfg.burst_window});
        c_free    = r_valid[r_didx] && !r_broken[r_didx] && c_expired;
        c_last    = r_dv && (r_didx == IDX_W'(N - 1));
    end

    // New contents of the reported entry: kept entry or fresh allocation.
    always_comb begin
        n_keep  = r_hit && !r_hit_free;
        n_slot  = n_keep ? r_hit_slot : r_free_slot;
        if (!n_keep) begin
            n_fail = ecbt_pkg::FAIL_W'(1);
        end else if (r_hit_word.failures == ecbt_pkg::FAIL_MAX) begin
            n_fail = ecbt_pkg::FAIL_MAX;
        end else begin
            n_fail = r_hit_word.failures + ecbt_pkg::FAIL_W'(1);
        end
        n_ws    = n_keep ? r_hit_word.window_start : r_clock_now;
        n_trip  = (n_fail >= i_cfg.evict_threshold);
        n_bu    = n_trip ? (r_clock_now + {16'd0, i_cfg.trip_hold})
                         : r_hit_word.broken_until;
        n_write = (r_state == ST_UPDATE) && (r_op == ecbt_pkg::OP_REPORT)
                  && !(r_hit && r_hit_brk) && (n_keep || r_free_found);
        // Idle entries are freed and the reported slot is claimed.
        n_valid = r_valid & ~r_free_vec;
        if (n_write) begin
            n_valid[n_slot] = 1'b1;
        end
    end

    // Memory request; sweep and update never overlap, so no forwarding.
    always_comb begin
        o_ram_req.re                 = c_issue;
        o_ram_req.raddr              = r_rd_cnt[IDX_W-1:0];
        o_ram_req.we                 = n_write;
        o_ram_req.waddr              = n_slot;
        o_ram_req.wdata.key          = r_key;
        o_ram_req.wdata.failures     = n_trip ? '0 : n_fail;
        o_ram_req.wdata.window_start = n_ws;
        o_ram_req.wdata.broken_until = n_bu;
    end

    assign n_load = (r_state == ST_RESULT) && (!r_out_valid || o_result.ready);

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clock_now <= '0;
            r_valid     <= '0;
            r_broken    <= '0;
            r_rd_cnt    <= '0;
            r_dv        <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item.valid) begin
                        r_op         <= ecbt_pkg::t_op'(i_item.operation);
                        r_key        <= i_item.host_key;
                        r_rd_cnt     <= '0;
                        r_dv         <= 1'b0;
                        r_hit        <= 1'b0;
                        r_hit_brk    <= 1'b0;
                        r_hit_free   <= 1'b0;
                        r_free_found <= 1'b0;
                        r_free_vec   <= '0;
                        r_avail      <= 1'b0;
                        r_became     <= 1'b0;
                        if (i_item.operation == ecbt_pkg::OP_NONE) begin
                            r_code  <= ecbt_pkg::CODE_DONE;
                            r_state <= ST_RESULT;
                        end else if ((i_item.operation == ecbt_pkg::OP_REPORT)
                                     && !i_item.is_disconnect) begin
                            r_code  <= ecbt_pkg::CODE_IGNORED;
                            r_state <= ST_RESULT;
                        end else begin
                            r_code <= ecbt_pkg::CODE_DONE;
                            if (i_item.operation == ecbt_pkg::OP_TICK) begin
                                r_clock_now <= r_clock_now + 32'd1;
                            end
                            r_state <= ST_SWEEP;
                        end
                    end
                end

                ST_SWEEP: begin
                    // Issue side; no read is issued after the last entry's read.
                    r_dv   <= c_issue;
                    r_didx <= r_rd_cnt[IDX_W-1:0];
                    if (c_issue) begin
                        r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                    end
                    // Returning data side.
                    if (r_dv) begin
                        if (r_op == ecbt_pkg::OP_TICK) begin
                            if (r_valid[r_didx] && r_broken[r_didx]
                                && (i_ram_rdata.broken_until == r_clock_now)) begin
                                r_broken[r_didx] <= 1'b0;
                            end
                        end else begin
                            if (c_match) begin
                                r_hit      <= 1'b1;
                                r_hit_brk  <= r_broken[r_didx];
                                r_hit_free <= c_free;
                                r_hit_slot <= r_didx;
                                r_hit_word <= i_ram_rdata;
                            end
                            if (c_free) begin
                                r_free_vec[r_didx] <= 1'b1;
                            end
                            if ((!r_valid[r_didx] || c_free) && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_slot  <= r_didx;
                            end
                        end
                    end
                    if (c_last) begin
                        r_state <= ST_UPDATE;
                    end
                end

                ST_UPDATE: begin
                    unique case (r_op)
                        ecbt_pkg::OP_QUERY: begin
                            r_avail <= !(r_hit && r_hit_brk);
                        end
                        ecbt_pkg::OP_REPORT: begin
                            if (r_hit && r_hit_brk) begin
                                r_code <= ecbt_pkg::CODE_BROKEN;
                            end else begin
                                // Free idle entries, then claim or refresh the slot.
                                r_valid <= n_valid;
                                if (n_write) begin
                                    r_broken[n_slot] <= n_trip
                                                        && (i_cfg.trip_hold != '0);
                                    r_became         <= n_trip;
                                end else begin
                                    r_code <= ecbt_pkg::CODE_FULL;
                                end
                            end
                        end
                        default: begin
                            r_avail <= 1'b0;
                        end
                    endcase
                    r_state <= ST_RESULT;
                end

                ST_RESULT: begin
                    if (n_load) begin
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: loaded from the finished item, cleared by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_avail  <= r_avail;
            r_out_code   <= r_code;
            r_out_became <= r_became;
        end
    end

    assign i_item.ready           = (r_state == ST_IDLE);
    assign o_result.valid         = r_out_valid;
    assign o_result.available     = r_out_avail;
    assign o_result.result_code   = r_out_code;
    assign o_result.became_broken = r_out_became;

endmodule

FILE: src/endpoint_circuit_breaker_table.sv
// ============================================================================
// endpoint_circuit_breaker_table
// Keyed health table of endpoints with failure bursts and a broken TTL.
// ============================================================================
//
//  Channel    Direction  Handshake      Payload
//  i_item     in         valid/ready    operation, host_key, is_disconnect
//  o_result   out        valid/ready    available, result_code, became_broken
//  i_cfg_*    in         write enable   i_cfg_idx, i_cfg_data
//
// Queries, disconnect reports and ticks sweep the entry memory one entry per
// cycle, a rate set by the single read port of the entry memory. Operation
// three and non-disconnect reports skip the sweep. One item is in work at a
// time; the next one is taken in the cycle after the result is loaded.
// Reset is synchronous and active low; it clears the valid and broken flags
// and the tick clock, and needs no clearing pass.
// A finished result waits in the output register while the next item is
// taken; a stalled output holds the item after it in its last state.
//
module endpoint_circuit_breaker_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ecbt_in_if.sink                      i_item,
    ecbt_out_if.source                   o_result,
    input  logic                         i_cfg_we,
    input  logic [ecbt_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [ecbt_pkg::CFG_W-1:0]   i_cfg_data
);

    ecbt_pkg::t_cfg     cfg;
    ecbt_pkg::t_ram_req ram_req;
    ecbt_pkg::t_entry   ram_rdata;

    // Configuration registers.
    ecbt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Entry memory.
    ecbt_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // Sweep and update sequencer.
    ecbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (i_item),
        .o_result    (o_result),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    // The block takes one item at a time, so ready drops after a transfer in.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("input taken while an item is still in work");

    // An endpoint only becomes broken on a completed report.
    a_became_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.became_broken
        |-> o_result.result_code == ecbt_pkg::CODE_DONE && !o_result.available)
        else $error("became_broken with a non-done result");

    // Availability is only reported for completed queries.
    a_avail_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.available
        |-> o_result.result_code == ecbt_pkg::CODE_DONE)
        else $error("available set on a non-done result");

endmodule
